// File: sv/ppm_pulse_train_generator_unit_macros.svh
// Assertion macros for the PPM pulse train generator.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef PPM_PULSE_TRAIN_GENERATOR_UNIT_MACROS_SVH
`define PPM_PULSE_TRAIN_GENERATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PPM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define PPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/ppm_ptg_pkg.sv
// Shared types and constants of the PPM pulse train generator.
// No dependencies; used by the interfaces and all modules.
package ppm_ptg_pkg;

    localparam int CH_IDX_W  = 4;
    localparam int VAL_W     = 15;
    localparam int GAP_W     = 12;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [GAP_W-1:0] RESET_GAP      = 12'd300;
    localparam logic [VAL_W-1:0] RESET_LEAD     = 15'd350;
    localparam int               RESET_CHANNELS = 6;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD = 1'b1;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'b001,
        CMD_WRITE      = 3'b010,
        CMD_WRITE_LAST = 3'b100
    } t_cmd_kind;

    typedef struct packed {
        logic                operation;
        logic [CH_IDX_W-1:0] channel_index;
        logic [VAL_W-1:0]    channel_value;
        logic                last_of_write;
    } t_in_item;

    typedef struct packed {
        logic pin_level;
        logic frame_busy;
        logic slot_end;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind           kind;
        logic                store_en;
        logic [CH_IDX_W-1:0] channel_index;
        logic [VAL_W-1:0]    channel_value;
        logic [CNT_W-1:0]    count;
    } t_cmd;

endpackage

// File: sv/ppm_ptg_in_if.sv
// Input channel of the PPM pulse train generator: valid, ready and one item.
// Depends on ppm_ptg_pkg.
interface ppm_ptg_in_if import ppm_ptg_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/ppm_ptg_out_if.sv
// Result channel of the PPM pulse train generator: valid, ready and one result.
// Depends on ppm_ptg_pkg.
interface ppm_ptg_out_if import ppm_ptg_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/ppm_pulse_train_generator_unit.sv
// PPM pulse train generator top level: front end with a two-entry command queue, back end.
// Depends on ppm_ptg_pkg, the channel interfaces, ppm_ptg_front and ppm_ptg_back.
// An item passes through the command queue and then the result register before its result can transfer.
// Throughput: one item per cycle while the result channel is not stalled; the back end updates the slot per command.
// Reset (synchronous, active low) clears the stores, loads gap 300, lead 350, six channels.
`include "ppm_pulse_train_generator_unit_macros.svh"
module ppm_pulse_train_generator_unit import ppm_ptg_pkg::*; #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_wdata,
    ppm_ptg_in_if.sink           i_in,
    ppm_ptg_out_if.source        o_out
);

    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    ppm_ptg_front #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_q_valid(q_valid),
        .o_q_cmd  (q_cmd),
        .i_q_pop  (q_pop)
    );

    ppm_ptg_back #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_out      (o_out)
    );

    `PPM_ASSERT_IMPLIES(a_pop_needs_entry, i_clk, i_rst_n, q_pop, q_valid,
        "queue popped while empty")
    `PPM_ASSERT_IMPLIES(a_no_pop_on_stall, i_clk, i_rst_n, o_out.valid && !o_out.ready,
        !q_pop, "command executed while result stalled")
    `PPM_ASSERT_NEXT(a_transfer_queued, i_clk, i_rst_n, i_in.valid && i_in.ready,
        q_valid, "transferred item missing from queue")
    `PPM_ASSERT_IMPLIES(a_idle_pin_high, i_clk, i_rst_n,
        o_out.valid && !o_out.data.frame_busy, o_out.data.pin_level, "pin low while idle")

endmodule

// File: sv/ppm_ptg_front.sv
// Front end: accepts input items, classifies them into commands and queues them.
// Depends on ppm_ptg_pkg and ppm_ptg_in_if.
module ppm_ptg_front import ppm_ptg_pkg::*; #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ppm_ptg_in_if.sink   i_in,
    output logic         o_q_valid,
    output t_cmd         o_q_cmd,
    input  logic         i_q_pop
);

    t_cmd             cls_cmd;
    logic [CNT_W-1:0] cnt_raw;
    logic             push;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        cnt_raw = {1'b0, i_in.data.channel_index} + CNT_W'(1);
        cls_cmd.channel_index = i_in.data.channel_index;
        cls_cmd.channel_value = i_in.data.channel_value;
        cls_cmd.store_en      = int'(i_in.data.channel_index) < MAX_CHANNELS;
        cls_cmd.count         = (int'(cnt_raw) > MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS) : cnt_raw;
        if (i_in.data.operation == OP_WRITE) begin
            cls_cmd.kind = i_in.data.last_of_write ? CMD_WRITE_LAST : CMD_WRITE;
        end else begin
            cls_cmd.kind = CMD_TICK;
        end
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_cmd    = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_q_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_q_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cls_cmd;
        end
    end

endmodule

// File: sv/ppm_ptg_back.sv
// Back end: channel store, frame snapshot, slot timing and the result register.
// Depends on ppm_ptg_pkg and ppm_ptg_out_if.
module ppm_ptg_back import ppm_ptg_pkg::*; #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_wdata,
    input  logic                 i_q_valid,
    input  t_cmd                 i_q_cmd,
    output logic                 o_q_pop,
    ppm_ptg_out_if.source        o_out
);

    localparam int AW = $clog2(MAX_CHANNELS + 1);
    localparam int SW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [AW-1:0] ACT_RESET =
        AW'((RESET_CHANNELS < MAX_CHANNELS) ? RESET_CHANNELS : MAX_CHANNELS);

    logic [GAP_W-1:0] r_gap;
    logic [VAL_W-1:0] r_lead;
    logic [VAL_W-1:0] r_store [MAX_CHANNELS];
    logic [VAL_W-1:0] r_snap  [MAX_CHANNELS];
    logic [AW-1:0]    r_active;
    logic [AW-1:0]    r_slot;
    logic [VAL_W-1:0] r_tick;
    logic             r_busy;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [VAL_W-1:0] n_store [MAX_CHANNELS];
    logic [VAL_W-1:0] n_snap  [MAX_CHANNELS];
    logic [AW-1:0]    n_active;
    logic [AW-1:0]    n_slot;
    logic [VAL_W-1:0] n_tick;
    logic             n_busy;
    t_out_item        n_out;

    logic             pop;
    logic             tick_done;
    logic             pin_now;
    logic             pin_inc;
    logic [VAL_W-1:0] next_len;
    logic [VAL_W-1:0] cur_len;
    logic [AW-1:0]    slot_prev;
    logic [VAL_W:0]   gap_ext;

    assign pop     = i_q_valid && (!r_out_valid || o_out.ready);
    assign o_q_pop = pop;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign slot_prev = r_slot - AW'(1);
    assign cur_len   = (r_slot == '0) ? r_lead : r_snap[slot_prev[SW-1:0]];
    assign gap_ext   = {{(VAL_W + 1 - GAP_W){1'b0}}, r_gap};
    assign tick_done = (r_tick >= cur_len);
    assign pin_now   = ({1'b0, r_tick} + gap_ext) < {1'b0, cur_len};
    assign pin_inc   = ({1'b0, r_tick} + (VAL_W + 1)'(1) + gap_ext) < {1'b0, cur_len};
    assign next_len  = r_snap[r_slot[SW-1:0]];

    always_comb begin
        n_store  = r_store;
        n_snap   = r_snap;
        n_active = r_active;
        n_slot   = r_slot;
        n_tick   = r_tick;
        n_busy   = r_busy;
        n_out.pin_level  = 1'b1;
        n_out.frame_busy = r_busy;
        n_out.slot_end   = 1'b0;

        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (i_q_cmd.store_en && ({1'b0, i_q_cmd.channel_index} == CNT_W'(i))) begin
                n_store[i] = i_q_cmd.channel_value;
            end
        end

        case (i_q_cmd.kind)
            CMD_TICK: begin
                n_store = r_store;
                if (r_busy) begin
                    if (tick_done) begin
                        n_out.slot_end = 1'b1;
                        n_tick = '0;
                        if (r_slot >= r_active) begin
                            n_busy = 1'b0;
                            n_slot = '0;
                            n_out.pin_level = 1'b1;
                        end else begin
                            n_slot = r_slot + AW'(1);
                            n_out.pin_level = {1'b0, next_len} > gap_ext;
                        end
                    end else begin
                        n_tick = r_tick + VAL_W'(1);
                        n_out.pin_level = pin_inc;
                    end
                end
            end
            CMD_WRITE: begin
                n_out.pin_level = r_busy ? pin_now : 1'b1;
            end
            CMD_WRITE_LAST: begin
                n_active = AW'(i_q_cmd.count);
                if (r_busy) begin
                    n_out.pin_level = pin_now;
                end else begin
                    n_snap = n_store;
                    n_slot = '0;
                    n_tick = '0;
                    n_busy = 1'b1;
                    n_out.pin_level = {1'b0, r_lead} > gap_ext;
                end
            end
            default: begin
                n_store = r_store;
            end
        endcase
        n_out.frame_busy = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap  <= RESET_GAP;
            r_lead <= RESET_LEAD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAP: begin
                    r_gap <= i_cfg_wdata[GAP_W-1:0];
                end
                CFG_LEAD: begin
                    r_lead <= i_cfg_wdata;
                end
                default: begin
                    r_gap <= r_gap;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_store[i] <= '0;
                r_snap[i]  <= '0;
            end
            r_active <= ACT_RESET;
            r_slot   <= '0;
            r_tick   <= '0;
            r_busy   <= 1'b0;
        end else if (pop) begin
            r_store  <= n_store;
            r_snap   <= n_snap;
            r_active <= n_active;
            r_slot   <= n_slot;
            r_tick   <= n_tick;
            r_busy   <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

endmodule

// File: verif/ppm_ptg_checker.sv
// Checker for the PPM pulse train generator: watches the register port and both channels,
// predicts the pulse train and compares every result transfer. Depends on ppm_ptg_pkg
// and the two channel interfaces.
module ppm_ptg_checker import ppm_ptg_pkg::*; #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_wdata,
    ppm_ptg_in_if                i_in,
    ppm_ptg_out_if               i_out,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_CAP = 100;

    logic [GAP_W-1:0] gap_len;
    logic [VAL_W-1:0] lead_len;
    logic [VAL_W-1:0] channel_len [MAX_CHANNELS];
    logic [VAL_W-1:0] frame_len [MAX_CHANNELS];
    logic [CNT_W-1:0] active_count;
    logic [CNT_W-1:0] slot_no;
    logic [VAL_W-1:0] slot_ticks;
    logic             in_frame;
    t_out_item        pending_levels [$];
    int               fails;

    function automatic void reset_train();
        gap_len = RESET_GAP;
        lead_len = RESET_LEAD;
        foreach (channel_len[i]) channel_len[i] = '0;
        foreach (frame_len[i]) frame_len[i] = '0;
        active_count = CNT_W'((RESET_CHANNELS < MAX_CHANNELS) ? RESET_CHANNELS : MAX_CHANNELS);
        slot_no = '0;
        slot_ticks = '0;
        in_frame = 1'b0;
    endfunction

    function automatic int unsigned slot_length();
        int idx;
        idx = int'(slot_no) - 1;
        if (slot_no == '0) begin
            return lead_len;
        end
        if (idx < MAX_CHANNELS) begin
            return frame_len[idx];
        end
        return 0;
    endfunction

    function automatic logic line_level();
        int unsigned len;
        int unsigned high_part;
        if (!in_frame) begin
            return 1'b1;
        end
        len = slot_length();
        high_part = (len > gap_len) ? len - gap_len : 0;
        return (slot_ticks < high_part);
    endfunction

    function automatic t_out_item advance_train(input t_in_item item);
        t_out_item   res;
        int unsigned cnt;
        res.slot_end = 1'b0;
        if (item.operation == OP_WRITE) begin
            if (item.channel_index < MAX_CHANNELS) begin
                channel_len[item.channel_index] = item.channel_value;
            end
            if (item.last_of_write) begin
                cnt = item.channel_index + 1;
                active_count = (cnt > MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS) : CNT_W'(cnt);
                if (!in_frame) begin
                    frame_len = channel_len;
                    slot_no = '0;
                    slot_ticks = '0;
                    in_frame = 1'b1;
                end
            end
        end else if (in_frame) begin
            if (slot_ticks >= slot_length()) begin
                res.slot_end = 1'b1;
                slot_ticks = '0;
                if (slot_no >= active_count) begin
                    in_frame = 1'b0;
                    slot_no = '0;
                end else begin
                    slot_no = slot_no + 1'b1;
                end
            end else begin
                slot_ticks = slot_ticks + 1'b1;
            end
        end
        res.pin_level = line_level();
        res.frame_busy = in_frame;
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            reset_train();
            pending_levels.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_GAP) begin
                    gap_len = i_cfg_wdata[GAP_W-1:0];
                end else if (i_cfg_idx == CFG_LEAD) begin
                    lead_len = i_cfg_wdata;
                end
            end
            if (i_in.valid && i_in.ready) begin
                pending_levels.push_back(advance_train(i_in.data));
            end
            if (i_out.valid && i_out.ready) begin
                if (pending_levels.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_CAP) begin
                        $display("%0t: unexpected result transfer pin=%b busy=%b end=%b",
                                 $time, i_out.data.pin_level, i_out.data.frame_busy,
                                 i_out.data.slot_end);
                    end
                end else begin
                    want = pending_levels.pop_front();
                    if (want !== i_out.data) begin
                        fails++;
                        if (fails <= REPORT_CAP) begin
                            $display("%0t: expected pin=%b busy=%b end=%b got %b %b %b",
                                     $time, want.pin_level, want.frame_busy, want.slot_end,
                                     i_out.data.pin_level, i_out.data.frame_busy,
                                     i_out.data.slot_end);
                        end
                    end
                end
            end
        end
        o_pending <= pending_levels.size();
        o_fail_count <= fails;
    end

endmodule

// File: verif/ppm_pulse_train_generator_unit_tb.sv
// Top of the PPM pulse train generator testbench: clock, reset, timing registers and item
// stimulus under several idling phases. Depends on ppm_ptg_pkg, the channel interfaces,
// the generator and ppm_ptg_checker, which does all prediction and comparison.
module ppm_pulse_train_generator_unit_tb import ppm_ptg_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CHANNELS = 16;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 360;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [VAL_W-1:0]     cfg_wdata;
    logic                 frame_running;
    int                   send_idle;
    int                   recv_stall;
    int                   pending;
    int                   fail_count;
    int                   cycles;
    int                   items_sent;
    int                   cur_lead;

    ppm_ptg_in_if  in_if ();
    ppm_ptg_out_if out_if ();

    ppm_pulse_train_generator_unit #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    ppm_ptg_checker #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .i_out       (out_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_running <= 1'b0;
        end else if (out_if.valid && out_if.ready) begin
            frame_running <= out_if.data.frame_busy;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_in_item make_item(input logic op, input int idx, input int val,
                                           input logic last);
        t_in_item item;
        item.operation = op;
        item.channel_index = CH_IDX_W'(idx);
        item.channel_value = VAL_W'(val);
        item.last_of_write = last;
        return item;
    endfunction

    function automatic t_in_item tick_item();
        return make_item(OP_TICK, $urandom_range(15), $urandom_range(32767),
                         1'($urandom_range(1)));
    endfunction

    task automatic push(input t_in_item item);
        if (send_idle != 0 && $urandom_range(99) < send_idle) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        in_if.valid <= 1'b1;
        in_if.data <= item;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // Ticks the running frame out so that the next register write finds the block idle.
    task automatic settle();
        drain();
        while (frame_running) begin
            repeat (8) push(tick_item());
            drain();
        end
    endtask

    task automatic set_timing(input int gap, input int lead);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_GAP;
        cfg_wdata <= VAL_W'(gap);
        @(posedge i_clk);
        cfg_idx <= CFG_LEAD;
        cfg_wdata <= VAL_W'(lead);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cur_lead = lead;
    endtask

    // Mostly complete frame writes followed by about enough ticks to send the frame;
    // sometimes the ticks stop early so that writes land in a running frame.
    task automatic run_random(input int quota);
        int start;
        int k;
        int val;
        int frame_ticks;
        int n_ticks;
        start = items_sent;
        while (items_sent - start < quota) begin
            if ($urandom_range(99) < 70) begin
                k = ($urandom_range(9) == 0) ? $urandom_range(16, 1) : $urandom_range(4, 1);
                frame_ticks = cur_lead + 1;
                for (int c = 0; c < k; c++) begin
                    val = ($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(15);
                    frame_ticks += val + 1;
                    push(make_item(OP_WRITE, c, val, c == k - 1));
                end
                if ($urandom_range(99) < 80) begin
                    n_ticks = frame_ticks + $urandom_range(4);
                end else begin
                    n_ticks = $urandom_range(frame_ticks);
                end
                repeat (n_ticks) push(tick_item());
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    push(make_item(1'($urandom_range(1)), $urandom_range(15),
                                   $urandom_range(31), $urandom_range(3) == 0));
                end
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_GAP;
        cfg_wdata <= '0;
        in_if.valid <= 1'b0;
        in_if.data <= '0;
        send_idle = 0;
        recv_stall = 0;
        items_sent = 0;
        cur_lead = RESET_LEAD;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_timing(3, 4);
        push(make_item(OP_TICK, 15, 32767, 1'b1));
        push(make_item(OP_WRITE, 15, 32767, 1'b0));
        push(make_item(OP_WRITE, 15, 0, 1'b0));
        push(make_item(OP_WRITE, 0, 0, 1'b0));
        push(make_item(OP_WRITE, 1, 3, 1'b0));
        push(make_item(OP_WRITE, 2, 9, 1'b1));
        repeat (3) push(tick_item());
        push(make_item(OP_WRITE, 3, 6, 1'b1));
        settle();
        push(make_item(OP_WRITE, 15, 2, 1'b1));
        settle();

        set_timing(4095, 40);
        push(make_item(OP_WRITE, 0, 30, 1'b1));
        repeat (41 + 31 + 4) push(tick_item());
        settle();

        for (int p = 0; p < 4; p++) begin
            if (p == 0) begin
                set_timing(0, 1);
            end else begin
                set_timing($urandom_range(12), $urandom_range(24, 1));
            end
            send_idle = (p == 1) ? 84 : (p == 3) ? 32 : 0;
            recv_stall = (p == 2) ? 84 : (p == 3) ? 32 : 0;
            run_random(PHASE_ITEMS);
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
